// File: rtl/core/dynamic_quantum_ready_queue_macros.svh
// Assertion macros for the dynamic quantum ready queue.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef DYNAMIC_QUANTUM_READY_QUEUE_MACROS_SVH
`define DYNAMIC_QUANTUM_READY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define DQRQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define DQRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/dqrq_pkg.sv
// Shared constants, types and codes of the dynamic quantum ready queue.
// No dependencies; imported by every module of the block.
package dqrq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_CLASSES = 4;
    localparam int TIME_BITS   = 16;

    // Storage geometry
    localparam int NUM_FIFOS  = 2 * NUM_CLASSES;
    localparam int NUM_SLOTS  = NUM_FIFOS * QUEUE_DEPTH;
    localparam int FIFO_W     = $clog2(NUM_FIFOS);
    localparam int SLOT_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CLS_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W     = FIFO_W + SLOT_W;
    localparam int MEM_DEPTH  = 1 << ADDR_W;

    // Arithmetic widths
    localparam int TIME_W     = TIME_BITS;
    localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
    localparam int TOTAL_W    = TIME_BITS + $clog2(NUM_SLOTS);
    localparam int QMAX_W     = 16;
    localparam int QMAX_RESET = 16;

    // Stream payload widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 64;

    typedef enum logic {
        CMD_PUSH  = 1'b0,
        CMD_FETCH = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [15:0]       tag;
        logic [TIME_W-1:0] burst;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

// File: rtl/core/dqrq_div.sv
// Restoring serial divider, one quotient bit per cycle, for the quantum average.
// Depends on dqrq_pkg for the total and count widths.
module dqrq_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [dqrq_pkg::TOTAL_W-1:0] i_dividend,
    input  logic [dqrq_pkg::CNT_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [dqrq_pkg::TOTAL_W-1:0] o_quotient
);
    import dqrq_pkg::*;

    localparam int STEP_W = $clog2(TOTAL_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [TOTAL_W-1:0] r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;

    logic [CNT_W:0]    w_shift;
    logic [CNT_W:0]    w_diff;
    logic              w_ge;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        w_shift = {r_rem, r_quo[TOTAL_W-1]};
        w_diff  = w_shift - {1'b0, r_div};
        w_ge    = (w_shift >= {1'b0, r_div});
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(TOTAL_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift dividend into quotient, keep the running remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[TOTAL_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_shift[CNT_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: rtl/core/dqrq_store.sv
// Entry memory of all short and long FIFOs, addressed by FIFO index and slot.
// Depends on dqrq_pkg for the entry type and address width.
module dqrq_store (
    input  logic                 i_clk,
    input  dqrq_pkg::t_mem_req   i_req,
    output dqrq_pkg::t_entry     o_rdata
);
    import dqrq_pkg::*;

    t_entry r_mem [MEM_DEPTH];
    t_entry r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/dynamic_quantum_ready_queue.sv
// Dynamic quantum ready queue: sequencer, FIFO pointers, totals and result register.
// Depends on dqrq_pkg, dqrq_div, dqrq_store and the assertion macro header.
//
// Requests enter on s_axis: tuser is the command (0 push, 1 fetch), tdata carries
// thread tag, priority class and remaining time. Each request gives exactly one
// result on m_axis: tuser is the status, tdata the fetched entry, the short-queue
// flag, the current quantum and the thread count. The user must write the quantum
// clamp through i_cfg_we / i_cfg_wdata only while no request is in work; the block
// itself does not enforce this. A push runs through S_DIV and S_FIN, a fetch that
// leaves threads behind through S_READ, S_DIV and S_FIN, a fetch of the last thread
// through S_READ and S_FIN, a fetch while empty straight to S_FIN; S_FIN hands the
// result to the output register. The serial divider that forms total / count, one
// quotient bit per cycle over TOTAL_W (23) bits, sets the pace. One request is in work
// at a time, since s_axis_tready is high only while the sequencer is idle.
// Reset is synchronous, active low: all FIFOs empty, totals zero, quantum -1, clamp
// 16. The entry memory is not cleared; slots are read only once written.
// Stall: a finished result waits in the output register; the next request can be
// accepted meanwhile, and its result waits in the sequencer until the register is free.
module dynamic_quantum_ready_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration: quantum clamp
    input  logic                            i_cfg_we,
    input  logic [15:0]                     i_cfg_wdata,
    // Request channel
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: thread_tag[15:0], priority_class[17:16], remaining_time[33:18], zero pad
    input  logic [dqrq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: command[0]
    input  logic                            s_axis_tuser,
    // Result channel
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: fetched_tag[15:0], fetched_class[17:16], fetched_time[33:18],
    //        went_short[34], quantum_now[51:35], ready_count[59:52], zero pad
    output logic [dqrq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: status[1:0]
    output logic [1:0]                      m_axis_tuser
);
    import dqrq_pkg::*;

    `include "dynamic_quantum_ready_queue_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_FIN
    } t_state;

    localparam logic [16:0] QUANT_RESET = '1;

    t_state             r_state;
    t_cmd               r_cmd;
    logic [15:0]        r_tag;
    logic [CLS_W-1:0]   r_cls;
    logic [TIME_W-1:0]  r_burst;
    logic [TOTAL_W-1:0] r_new_total;
    logic [CNT_W-1:0]   r_new_count;
    logic [FIFO_W-1:0]  r_fifo;

    logic [SLOT_W-1:0]  r_heads [NUM_FIFOS];
    logic [FILL_W-1:0]  r_fill  [NUM_FIFOS];
    logic [TOTAL_W-1:0] r_total;
    logic [CNT_W-1:0]   r_count;
    logic [16:0]        r_quantum;
    logic [QMAX_W-1:0]  r_qmax;

    t_status            r_res_status;
    logic [15:0]        r_res_tag;
    logic [1:0]         r_res_cls;
    logic [TIME_W-1:0]  r_res_time;
    logic               r_res_short;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [15:0]        r_out_tag;
    logic [1:0]         r_out_cls;
    logic [15:0]        r_out_time;
    logic               r_out_short;
    logic [16:0]        r_out_quant;
    logic [7:0]         r_out_count;

    logic               w_in_acc;
    t_cmd               w_in_cmd;
    logic [15:0]        w_in_tag;
    logic [CLS_W-1:0]   w_in_cls;
    logic [TIME_W-1:0]  w_in_burst;
    logic [TOTAL_W-1:0] w_push_total;
    logic [CNT_W-1:0]   w_push_count;

    logic               w_any;
    logic [FIFO_W-1:0]  w_found;

    t_entry             w_rdata;
    t_mem_req           w_mem_req;
    logic [TOTAL_W-1:0] w_fetch_total;
    logic [CNT_W-1:0]   w_fetch_count;
    logic [FIFO_W-1:0]  w_fetch_cls;
    logic [SLOT_W-1:0]  w_head_next;

    logic               w_div_start;
    logic [TOTAL_W-1:0] w_div_dividend;
    logic [CNT_W-1:0]   w_div_divisor;
    logic               w_div_done;
    logic [TOTAL_W-1:0] w_quo;
    logic [QMAX_W-1:0]  w_q;
    logic               w_to_short;
    logic [FIFO_W-1:0]  w_tgt;
    logic               w_tgt_full;
    logic [SLOT_W+1:0]  w_tail_sum;
    logic [SLOT_W-1:0]  w_tail;
    logic               w_push_write;
    logic               w_hand;

    // Unpack the request
    always_comb begin
        w_in_acc   = s_axis_tvalid && s_axis_tready;
        w_in_cmd   = t_cmd'(s_axis_tuser);
        w_in_tag   = s_axis_tdata[15:0];
        w_in_burst = TIME_W'(s_axis_tdata[33:18]);
        if (int'(s_axis_tdata[17:16]) >= NUM_CLASSES) begin
            w_in_cls = CLS_W'(NUM_CLASSES - 1);
        end else begin
            w_in_cls = CLS_W'(s_axis_tdata[17:16]);
        end
        w_push_total = r_total + TOTAL_W'(w_in_burst);
        w_push_count = r_count + 1'b1;
    end

    // Find the first non-empty FIFO: short ones in class order, then long ones
    always_comb begin
        w_any   = 1'b0;
        w_found = '0;
        for (int k = NUM_FIFOS - 1; k >= 0; k--) begin
            if (r_fill[k] != '0) begin
                w_any   = 1'b1;
                w_found = FIFO_W'(k);
            end
        end
    end

    // Fetch bookkeeping on the entry read back from memory
    always_comb begin
        if (r_total >= TOTAL_W'(w_rdata.burst)) begin
            w_fetch_total = r_total - TOTAL_W'(w_rdata.burst);
        end else begin
            w_fetch_total = '0;
        end
        w_fetch_count = r_count - 1'b1;
        if (int'(r_fifo) < NUM_CLASSES) begin
            w_fetch_cls = r_fifo;
        end else begin
            w_fetch_cls = r_fifo - FIFO_W'(NUM_CLASSES);
        end
        if (r_heads[r_fifo] == SLOT_W'(QUEUE_DEPTH - 1)) begin
            w_head_next = '0;
        end else begin
            w_head_next = r_heads[r_fifo] + 1'b1;
        end
    end

    // Divider launch: push averages the new total, fetch the reduced one
    always_comb begin
        w_div_start = ((r_state == S_IDLE) && w_in_acc && (w_in_cmd == CMD_PUSH))
                   || ((r_state == S_READ) && (w_fetch_count != '0));
        if (r_state == S_READ) begin
            w_div_dividend = w_fetch_total;
            w_div_divisor  = w_fetch_count;
        end else begin
            w_div_dividend = w_push_total;
            w_div_divisor  = w_push_count;
        end
    end

    // Clamp the average and pick the target FIFO of a push
    always_comb begin
        if (w_quo > TOTAL_W'(r_qmax)) begin
            w_q = r_qmax;
        end else begin
            w_q = QMAX_W'(w_quo);
        end
        w_to_short = (32'(r_burst) <= 32'(w_q));
        w_tgt      = w_to_short ? FIFO_W'(r_cls) : FIFO_W'(r_cls) + FIFO_W'(NUM_CLASSES);
        w_tgt_full = (r_fill[w_tgt] == FILL_W'(QUEUE_DEPTH));
        w_tail_sum = (SLOT_W+2)'(r_heads[w_tgt]) + (SLOT_W+2)'(r_fill[w_tgt]);
        if (w_tail_sum >= (SLOT_W+2)'(QUEUE_DEPTH)) begin
            w_tail = SLOT_W'(w_tail_sum - (SLOT_W+2)'(QUEUE_DEPTH));
        end else begin
            w_tail = SLOT_W'(w_tail_sum);
        end
        w_push_write = (r_state == S_DIV) && w_div_done && (r_cmd == CMD_PUSH)
                    && !w_tgt_full;
    end

    // Result hand-over into the output register
    assign w_hand = (r_state == S_FIN) && (!r_out_valid || m_axis_tready);

    // Memory request
    always_comb begin
        w_mem_req.we          = w_push_write;
        w_mem_req.waddr       = {w_tgt, w_tail};
        w_mem_req.wdata.tag   = r_tag;
        w_mem_req.wdata.burst = r_burst;
        w_mem_req.raddr       = {w_found, r_heads[w_found]};
    end

    dqrq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    dqrq_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_mem_req),
        .o_rdata (w_rdata)
    );

    // Sequencer, scheduler state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_count     <= '0;
            r_quantum   <= QUANT_RESET;
            r_qmax      <= QMAX_W'(QMAX_RESET);
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_FIFOS; k++) begin
                r_heads[k] <= '0;
                r_fill[k]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_qmax <= i_cfg_wdata;
            end
            if (w_hand) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_cmd        <= w_in_cmd;
                        r_tag        <= w_in_tag;
                        r_cls        <= w_in_cls;
                        r_burst      <= w_in_burst;
                        r_new_total  <= w_push_total;
                        r_new_count  <= w_push_count;
                        r_fifo       <= w_found;
                        r_res_tag    <= '0;
                        r_res_cls    <= '0;
                        r_res_time   <= '0;
                        r_res_short  <= 1'b0;
                        if (w_in_cmd == CMD_PUSH) begin
                            r_res_status <= ST_OK;
                            r_state      <= S_DIV;
                        end else if (w_any) begin
                            r_res_status <= ST_OK;
                            r_state      <= S_READ;
                        end else begin
                            r_res_status <= ST_EMPTY;
                            r_state      <= S_FIN;
                        end
                    end
                end
                S_READ: begin
                    // Pop the head entry and drop its time from the total
                    r_res_tag        <= w_rdata.tag;
                    r_res_time       <= w_rdata.burst;
                    r_res_cls        <= 2'(w_fetch_cls);
                    r_res_short      <= (int'(r_fifo) < NUM_CLASSES);
                    r_heads[r_fifo]  <= w_head_next;
                    r_fill[r_fifo]   <= r_fill[r_fifo] - 1'b1;
                    r_count          <= w_fetch_count;
                    r_total          <= w_fetch_total;
                    r_state          <= (w_fetch_count != '0) ? S_DIV : S_FIN;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        if (r_cmd == CMD_PUSH) begin
                            if (w_tgt_full) begin
                                r_res_status <= ST_FULL;
                            end else begin
                                r_fill[w_tgt] <= r_fill[w_tgt] + 1'b1;
                                r_total       <= r_new_total;
                                r_count       <= r_new_count;
                                r_quantum     <= {1'b0, w_q};
                                r_res_short   <= w_to_short;
                            end
                        end else begin
                            r_quantum <= {1'b0, w_q};
                        end
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // Hand the result over once the output register is free
                    if (w_hand) begin
                        r_out_status <= r_res_status;
                        r_out_tag    <= r_res_tag;
                        r_out_cls    <= r_res_cls;
                        r_out_time   <= 16'(r_res_time);
                        r_out_short  <= r_res_short;
                        r_out_quant  <= r_quantum;
                        r_out_count  <= 8'(r_count);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {4'b0, r_out_count, r_out_quant, r_out_short,
                            r_out_time, r_out_cls, r_out_tag};

    // An accepted request closes the input until its result is handed to the output register
    `DQRQ_ASSERT_NEXT(a_accept_closes, i_clk, i_rst_n, w_in_acc, !s_axis_tready, "busy accept")
    // No threads held means no time left in the total
    `DQRQ_ASSERT_NOW(a_empty_total, i_clk, i_rst_n, r_count == '0, r_total == '0, "total left")
    // Once a thread is held the quantum has been computed
    `DQRQ_ASSERT_NOW(a_quant_set, i_clk, i_rst_n, r_count != '0, r_quantum != QUANT_RESET, "no quantum")

endmodule

// File: dv/dqrq_checker.sv
// Scoreboard for the dynamic quantum ready queue: predicts each result from the requests it sees.
// Depends on dqrq_pkg; watches the request, result and clamp-write ports of the block.
module dqrq_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [15:0]                     i_cfg_wdata,
    input  logic                            i_req_valid,
    input  logic                            i_req_ready,
    input  logic [dqrq_pkg::IN_DATA_W-1:0]  i_req_data,
    input  logic                            i_req_user,
    input  logic                            i_rsp_valid,
    input  logic                            i_rsp_ready,
    input  logic [dqrq_pkg::OUT_DATA_W-1:0] i_rsp_data,
    input  logic [1:0]                      i_rsp_user,
    output int                              o_errors,
    output int                              o_outstanding
);
    import dqrq_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] tag;
        logic [1:0]  cls;
        logic [15:0] burst;
        logic        in_short;
        logic [16:0] quantum;
        logic [7:0]  count;
    } t_reply;

    // Scheduler image: FIFOs 0..NUM_CLASSES-1 are short, the rest long
    logic [15:0]        slot_tag   [NUM_FIFOS][QUEUE_DEPTH];
    logic [15:0]        slot_burst [NUM_FIFOS][QUEUE_DEPTH];
    int unsigned        fifo_head  [NUM_FIFOS];
    int unsigned        fifo_used  [NUM_FIFOS];
    longint unsigned    burst_sum;
    int unsigned        thread_cnt;
    logic signed [16:0] cur_quantum;
    longint unsigned    quantum_clamp;

    t_reply reply_q[$];
    t_reply got;
    t_reply want;
    int     err_cnt = 0;

    function automatic longint unsigned clamped_avg(longint unsigned sum, int unsigned cnt);
        longint unsigned avg;
        avg = sum / cnt;
        return (avg < quantum_clamp) ? avg : quantum_clamp;
    endfunction

    // Apply one request to the image and return the result it must produce
    function automatic t_reply schedule_request(logic [IN_DATA_W-1:0] data, logic cmd);
        t_reply          r;
        logic [15:0]     tag;
        logic [15:0]     burst;
        int unsigned     cls;
        int unsigned     f;
        int unsigned     slot;
        longint unsigned q;
        logic            to_short;
        int              hit;
        r = '0;
        if (t_cmd'(cmd) == CMD_PUSH) begin
            tag   = data[15:0];
            cls   = data[17:16];
            burst = data[33:18];
            if (cls >= NUM_CLASSES) begin
                cls = NUM_CLASSES - 1;
            end
            q        = clamped_avg(burst_sum + burst, thread_cnt + 1);
            to_short = (burst <= q);
            f        = to_short ? cls : cls + NUM_CLASSES;
            if (fifo_used[f] >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                slot                = (fifo_head[f] + fifo_used[f]) % QUEUE_DEPTH;
                slot_tag[f][slot]   = tag;
                slot_burst[f][slot] = burst;
                fifo_used[f]++;
                burst_sum   += burst;
                thread_cnt++;
                cur_quantum = 17'(q);
                r.in_short  = to_short;
            end
        end else begin
            // Short FIFOs in class order win over all long FIFOs
            hit = -1;
            for (int i = 0; i < NUM_FIFOS; i++) begin
                if (hit < 0 && fifo_used[i] != 0) begin
                    hit = i;
                end
            end
            if (hit < 0) begin
                r.status = ST_EMPTY;
            end else begin
                slot       = fifo_head[hit];
                r.tag      = slot_tag[hit][slot];
                r.burst    = slot_burst[hit][slot];
                r.cls      = 2'(hit % NUM_CLASSES);
                r.in_short = (hit < NUM_CLASSES);
                fifo_head[hit] = (slot + 1) % QUEUE_DEPTH;
                fifo_used[hit]--;
                thread_cnt--;
                burst_sum = (burst_sum >= r.burst) ? burst_sum - r.burst : 0;
                // Keep the old quantum once the last thread is gone
                if (thread_cnt != 0) begin
                    cur_quantum = 17'(clamped_avg(burst_sum, thread_cnt));
                end
            end
        end
        r.quantum = cur_quantum;
        r.count   = 8'(thread_cnt);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_FIFOS; i++) begin
                fifo_head[i] = 0;
                fifo_used[i] = 0;
            end
            burst_sum     = 0;
            thread_cnt    = 0;
            cur_quantum   = -17'sd1;
            quantum_clamp = QMAX_RESET;
            reply_q.delete();
        end else begin
            // Retire the result first: it belongs to an older request
            if (i_rsp_valid && i_rsp_ready) begin
                got.status   = i_rsp_user;
                got.tag      = i_rsp_data[15:0];
                got.cls      = i_rsp_data[17:16];
                got.burst    = i_rsp_data[33:18];
                got.in_short = i_rsp_data[34];
                got.quantum  = i_rsp_data[51:35];
                got.count    = i_rsp_data[59:52];
                if (reply_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("ERROR: result with none pending: status %0d tag %h", got.status,
                                 got.tag);
                    end
                end else begin
                    want = reply_q.pop_front();
                    if (got !== want) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("ERROR: result mismatch at %0t", $realtime);
                            $display("  status exp %0d got %0d, tag exp %h got %h",
                                     want.status, got.status, want.tag, got.tag);
                            $display("  class exp %0d got %0d, time exp %h got %h",
                                     want.cls, got.cls, want.burst, got.burst);
                            $display("  short exp %b got %b, quantum exp %h got %h",
                                     want.in_short, got.in_short, want.quantum, got.quantum);
                            $display("  count exp %0d got %0d", want.count, got.count);
                        end
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                reply_q = {reply_q, schedule_request(i_req_data, i_req_user)};
            end
            if (i_cfg_we) begin
                quantum_clamp = i_cfg_wdata;
            end
        end
        o_errors      <= err_cnt;
        o_outstanding <= reply_q.size();
    end

endmodule

// File: dv/tb_dynamic_quantum_ready_queue.sv
// Top of the ready-queue testbench: clock, reset, request and result traffic, verdict.
// Depends on dqrq_pkg, the block and dqrq_checker, which predicts and compares.
module tb_dynamic_quantum_ready_queue;
    import dqrq_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_AFTER   = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [15:0]           i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tready = 1'b0;
    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    int          fail_count;
    int          outstanding;
    int          results_taken = 0;
    int          idle_cycles   = 0;
    bit          calm          = 1'b0;
    logic [15:0] clamp_now     = 16'(QMAX_RESET);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    dynamic_quantum_ready_queue uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    dqrq_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_req_data    (s_axis_tdata),
        .i_req_user    (s_axis_tuser),
        .i_rsp_valid   (m_axis_tvalid),
        .i_rsp_ready   (m_axis_tready),
        .i_rsp_data    (m_axis_tdata),
        .i_rsp_user    (m_axis_tuser),
        .o_errors      (fail_count),
        .o_outstanding (outstanding)
    );

    // Mostly short gaps, a few long ones; none in calm phases
    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 60);
    endfunction

    // Offer one request and hold it until the block takes it
    task automatic send_request(t_cmd cmd, logic [15:0] tag, logic [1:0] cls, logic [15:0] burst);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({burst, cls, tag});
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Change the clamp only once every result is back
    task automatic write_clamp(logic [15:0] value);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        clamp_now   = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One clamp setting, then a mix of pushes biased toward a hot class and fetches
    task automatic traffic_phase(logic [15:0] clamp, int n, int push_pct);
        logic [1:0]  hot;
        logic [1:0]  cls;
        logic [15:0] burst;
        int          pick;
        int          cv;
        int          v;
        write_clamp(clamp);
        calm = ($urandom_range(0, 3) == 0);
        hot  = 2'($urandom_range(0, 3));
        cv   = clamp_now;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                burst = 16'($urandom_range(0, 40));
            end else if (pick < 7) begin
                v = cv + int'($urandom_range(0, 8)) - 4;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
                burst = 16'(v);
            end else if (pick < 9) begin
                burst = 16'($urandom_range(0, 65535));
            end else begin
                burst = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            cls = $urandom_range(0, 1) ? hot : 2'($urandom_range(0, 3));
            if ($urandom_range(0, 99) < push_pct) begin
                send_request(CMD_PUSH, 16'($urandom_range(0, 65535)), cls, burst);
            end else begin
                send_request(CMD_FETCH, 16'($urandom_range(0, 65535)), cls, burst);
            end
        end
    endtask

    // Count taken results and watch for a stuck run
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_taken <= results_taken + 1;
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off so the input backs up
    initial begin
        int gap_left;
        bit held;
        gap_left = 0;
        held     = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && results_taken >= HOLD_AFTER) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (gap_left > 0) begin
                m_axis_tready <= 1'b0;
                gap_left--;
            end else begin
                m_axis_tready <= 1'b1;
                gap_left = pick_gap();
            end
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Fetch from an empty scheduler before any push
        send_request(CMD_FETCH, 16'hFFFF, 2'd3, 16'hFFFF);
        // Field extremes and both sides of the quantum
        send_request(CMD_PUSH, 16'h0000, 2'd0, 16'h0000);
        send_request(CMD_PUSH, 16'hFFFF, 2'd3, 16'hFFFF);
        send_request(CMD_PUSH, 16'h1234, 2'd1, 16'd16);
        send_request(CMD_PUSH, 16'h5A5A, 2'd2, 16'd17);
        // Drain past the last thread, then fetch while empty again
        repeat (5) send_request(CMD_FETCH, 16'h0000, 2'd0, 16'h0000);
        // Overfill the short FIFO of class 3
        repeat (QUEUE_DEPTH + 1) begin
            send_request(CMD_PUSH, 16'($urandom_range(0, 65535)), 2'd3, 16'h0000);
        end
        send_request(CMD_FETCH, 16'h0000, 2'd0, 16'h0000);

        traffic_phase(16'd0, 60, 80);
        traffic_phase(16'hFFFF, 60, 40);
        traffic_phase(16'd1, 60, 80);
        traffic_phase(16'($urandom_range(0, 65535)), 60, 50);
        traffic_phase(16'hFFFF, 60, 85);
        traffic_phase(16'd16, 60, 20);

        // Let every result come back, then allow for a stray one
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
